FILE: rtl/first_fit_interval_allocator_top_defines.svh
// Assertion macros for the first-fit interval allocator top level.
`ifndef FIRST_FIT_INTERVAL_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_INTERVAL_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every rising clock edge, held off while reset is high.
`define FFIA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed in first-fit allocator");
// Property checked at every rising clock edge, reset included.
`define FFIA_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed in first-fit allocator");
`else
`define FFIA_ASSERT(label, clk, rst, prop)
`define FFIA_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: rtl/ffia_pkg.sv
// Types and constants shared by the first-fit interval allocator modules.
package ffia_pkg;

   localparam int ACTION_W    = 1;
   localparam int DAY_W       = 7;
   localparam int DURATION_W  = 5;
   localparam int STATUS_W    = 2;
   localparam int RES_INDEX_W = 4;
   localparam int BUSY_W      = 5;
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 1;
   localparam int RSP_TDATA_W = 16;

   localparam logic [ACTION_W-1:0] ACT_ASSIGN = 1'b0;
   localparam logic [ACTION_W-1:0] ACT_COUNT  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

   localparam logic [BUSY_W-1:0] BUSY_MAX = 5'd31;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic err;
      logic hit;
      logic scan_done;
      logic out_free;
   } sts_type;

endpackage

FILE: rtl/ffia_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module ffia_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic                                   re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/ffia_ctrl.sv
// Controller state machine of the first-fit interval allocator.
module ffia_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  ffia_pkg::sts_type sts,
   output ffia_pkg::cmd_type cmd
);

   ffia_pkg::state_type state_ff;
   ffia_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffia_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ffia_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ffia_pkg::ST_SCAN;
            end
         end
         ffia_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
            // A range error, a free resource or the last row all end the scan.
            if (sts.err || sts.hit || sts.scan_done) begin
               state_in = ffia_pkg::ST_RESULT;
            end
         end
         ffia_pkg::ST_RESULT: begin
            if (sts.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ffia_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffia_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/ffia_dp.sv
// Datapath of the first-fit interval allocator: item registers, scan and result register.
module ffia_dp #(
   parameter int DAYS         = 128,
   parameter int RESOURCES    = 16,
   parameter int MAX_DURATION = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ffia_pkg::cmd_type                   cmd,
   output ffia_pkg::sts_type                   sts,
   input  logic [ffia_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [ffia_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ffia_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int IDX_W  = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
   localparam int CNT_W  = $clog2(RESOURCES + 1);
   localparam int BC_W   = (CNT_W > ffia_pkg::BUSY_W) ? CNT_W : ffia_pkg::BUSY_W;
   localparam int DAY_AW = $clog2(DAYS);
   localparam int SUM_W  = $clog2(DAYS + 256);
   localparam int DUR_CW = 8;

   // Item fields
   logic [ffia_pkg::DAY_W-1:0]      in_day;
   logic [ffia_pkg::DURATION_W-1:0] in_dur;
   logic [ffia_pkg::ACTION_W-1:0]   in_act;
   logic [DAYS-1:0]                 in_ones;
   logic [DAYS-1:0]                 in_mask;
   logic                            in_err;

   logic [ffia_pkg::ACTION_W-1:0] action_ff;
   logic [ffia_pkg::DAY_W-1:0]    day_ff;
   logic                          err_ff;
   logic [DAYS-1:0]               mask_ff;

   // Scan control
   logic [CNT_W-1:0]     rd_cnt_ff, rd_cnt_in;
   logic                 pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0]     pend_idx_ff;
   logic                 pend_rv_ff;
   logic [RESOURCES-1:0] row_vld_ff;
   logic                 issue;

   // Evaluation
   logic [DAYS-1:0]   rd_data;
   logic [DAYS-1:0]   row;
   logic [DAY_AW-1:0] day_idx;
   logic              is_assign;
   logic              eval;
   logic              hit;

   logic             hit_ff;
   logic [IDX_W-1:0] hit_idx_ff;
   logic [BC_W-1:0]  busy_ff;

   // Result register
   logic                             rsp_vld_ff;
   logic [ffia_pkg::RSP_TDATA_W-1:0] rsp_data_ff;
   logic [ffia_pkg::STATUS_W-1:0]    res_status;
   logic [ffia_pkg::RES_INDEX_W-1:0] res_index;
   logic [ffia_pkg::BUSY_W-1:0]      res_busy;

   assign in_day = req_tdata[ffia_pkg::DAY_W-1:0];
   assign in_dur = req_tdata[ffia_pkg::DAY_W +: ffia_pkg::DURATION_W];
   assign in_act = req_tuser[ffia_pkg::ACTION_W-1:0];

   assign in_ones = ~({DAYS{1'b1}} << in_dur);
   assign in_mask = in_ones << in_day;

   always_comb begin
      if (in_act == ffia_pkg::ACT_ASSIGN) begin
         in_err = (in_dur == '0)
               || (DUR_CW'(in_dur) > DUR_CW'(MAX_DURATION))
               || ((SUM_W'(in_day) + SUM_W'(in_dur)) > SUM_W'(DAYS));
      end else begin
         in_err = SUM_W'(in_day) >= SUM_W'(DAYS);
      end
   end

   assign issue     = cmd.scan && (rd_cnt_ff < CNT_W'(RESOURCES));
   assign row       = pend_rv_ff ? rd_data : '0;
   assign day_idx   = DAY_AW'(day_ff);
   assign is_assign = (action_ff == ffia_pkg::ACT_ASSIGN);
   assign eval      = cmd.scan && pend_vld_ff && !err_ff;
   assign hit       = eval && is_assign && ((row & mask_ff) == '0);

   assign sts.err       = err_ff;
   assign sts.hit       = hit;
   assign sts.scan_done = pend_vld_ff && (pend_idx_ff == IDX_W'(RESOURCES - 1));
   assign sts.out_free  = !rsp_vld_ff || rsp_tready;

   ffia_ram #(
      .WIDTH (DAYS),
      .DEPTH (RESOURCES)
   ) u_occ (
      .clock (clock),
      .we    (hit),
      .waddr (pend_idx_ff),
      .wdata (row | mask_ff),
      .re    (issue),
      .raddr (rd_cnt_ff[IDX_W-1:0]),
      .rdata (rd_data)
   );

   always_comb begin
      rd_cnt_in   = rd_cnt_ff;
      pend_vld_in = pend_vld_ff;
      if (cmd.load) begin
         rd_cnt_in   = '0;
         pend_vld_in = 1'b0;
      end else if (cmd.scan) begin
         pend_vld_in = issue;
         if (issue) begin
            rd_cnt_in = rd_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff   <= '0;
         pend_vld_ff <= 1'b0;
         row_vld_ff  <= '0;
      end else begin
         rd_cnt_ff   <= rd_cnt_in;
         pend_vld_ff <= pend_vld_in;
         if (hit) begin
            row_vld_ff[pend_idx_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= in_act;
         day_ff    <= in_day;
         err_ff    <= in_err;
         mask_ff   <= in_mask;
         hit_ff    <= 1'b0;
         busy_ff   <= '0;
      end else begin
         if (hit) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= pend_idx_ff;
         end
         if (eval && !is_assign) begin
            busy_ff <= busy_ff + BC_W'(row[day_idx]);
         end
      end
      if (issue) begin
         pend_idx_ff <= rd_cnt_ff[IDX_W-1:0];
         pend_rv_ff  <= row_vld_ff[rd_cnt_ff[IDX_W-1:0]];
      end
   end

   always_comb begin
      if (err_ff) begin
         res_status = ffia_pkg::ST_RANGE;
      end else if (is_assign && !hit_ff) begin
         res_status = ffia_pkg::ST_NOFREE;
      end else begin
         res_status = ffia_pkg::ST_OK;
      end
      res_index = hit_ff ? ffia_pkg::RES_INDEX_W'(hit_idx_ff) : '0;
      res_busy  = (busy_ff > BC_W'(ffia_pkg::BUSY_MAX)) ? ffia_pkg::BUSY_MAX
                                                         : busy_ff[ffia_pkg::BUSY_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_data_ff <= ffia_pkg::RSP_TDATA_W'({res_busy, res_index, res_status});
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: rtl/first_fit_interval_allocator_top.sv
// First-fit interval allocator: top level joining controller and datapath.
//
// The block keeps one occupancy row of DAYS slots for each of RESOURCES
// resources, all free after reset. An assign item asks for the slots from
// day up to day plus duration minus one; the block hands out the
// lowest-numbered resource whose slots in that window are all free and marks
// them. A count item returns how many resources are busy at one slot. Every
// item gives exactly one result item. Status is 0 on success, 1 when no
// resource has the window free and 2 when the interval is out of range
// (zero or overlong duration, window past the table, or a count slot past
// the table); nothing is marked on an error. The rows live in a RAM with a
// registered read port, and the controller scans them one per cycle. One
// item is in work at a time; the next item is accepted the cycle after a
// result is loaded, even while that result still waits on the output. The
// rows need no clearing pass: a valid flag per row makes a never-written
// row read as free.
`include "first_fit_interval_allocator_top_defines.svh"

module first_fit_interval_allocator_top #(
   parameter int DAYS         = 128,
   parameter int RESOURCES    = 16,
   parameter int MAX_DURATION = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   // Request channel.
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: day [6:0], duration [11:7], zero fill [15:12].
   input  logic [ffia_pkg::REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: action [0] (0 assign, 1 count).
   input  logic [ffia_pkg::REQ_TUSER_W-1:0] req_tuser,
   // Response channel.
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: status [1:0], resource_index [5:2],
   // busy_count [10:6], zero fill [15:11].
   output logic [ffia_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // Command and status bundles between the controller and the datapath.
   ffia_pkg::cmd_type cmd;
   ffia_pkg::sts_type sts;

   ffia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   ffia_dp #(
      .DAYS         (DAYS),
      .RESOURCES    (RESOURCES),
      .MAX_DURATION (MAX_DURATION)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // An accepted item keeps the input closed for at least the next cycle.
   `FFIA_ASSERT(a_one_item_in_work, clock, reset, (req_tvalid && req_tready) |=> !req_tready)

   // A new result only appears after the controller has finished an item.
   `FFIA_ASSERT(a_result_after_finish, clock, reset, $rose(rsp_tvalid) |-> $past(cmd.finish))

   // Slots are never marked for an item that failed its range check.
   `FFIA_ASSERT_ALWAYS(a_no_mark_on_error, clock, sts.hit |-> !sts.err)

endmodule

FILE: test/first_fit_interval_allocator_checker.sv
// Checker for the first-fit interval allocator: predicts each result and compares it.
module first_fit_interval_allocator_checker
   import ffia_pkg::*;
#(
   parameter int DAYS         = 128,
   parameter int RESOURCES    = 16,
   parameter int MAX_DURATION = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // Fields from bit 0: day, duration, zero fill.
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // Fields from bit 0: action.
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // Fields from bit 0: status, resource_index, busy_count, zero fill.
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     mismatches,
   output int                     pending,
   output int                     results_seen
);

   typedef struct packed {
      logic [STATUS_W-1:0]    status;
      logic [RES_INDEX_W-1:0] resource_index;
      logic [BUSY_W-1:0]      busy_count;
   } alloc_result_type;

   // One row of slot flags per resource, set where the slot is taken.
   logic [DAYS-1:0]  slot_map [RESOURCES];
   alloc_result_type awaited_results [$];

   // Applies one item to the shadow occupancy and returns the result it must give.
   function automatic alloc_result_type allocate_or_count(logic [ACTION_W-1:0] action,
                                                          int unsigned day,
                                                          int unsigned dur);
      alloc_result_type res;
      logic [DAYS-1:0]  window;
      int unsigned      taken;
      res = '0;
      if (action == ACT_ASSIGN) begin
         if (dur == 0 || dur > MAX_DURATION || day + dur > DAYS) begin
            res.status = ST_RANGE;
         end else begin
            res.status = ST_NOFREE;
            window = '0;
            for (int k = 0; k < dur; k++) window[day + k] = 1'b1;
            for (int r = 0; r < RESOURCES; r++) begin
               if ((slot_map[r] & window) == '0) begin
                  slot_map[r]        = slot_map[r] | window;
                  res.status         = ST_OK;
                  res.resource_index = RES_INDEX_W'(r);
                  break;
               end
            end
         end
      end else if (day >= DAYS) begin
         res.status = ST_RANGE;
      end else begin
         taken = 0;
         for (int r = 0; r < RESOURCES; r++) taken += slot_map[r][day];
         res.busy_count = (taken > BUSY_MAX) ? BUSY_MAX : BUSY_W'(taken);
      end
      return res;
   endfunction

   always @(posedge clock) begin
      alloc_result_type seen;
      alloc_result_type want;
      int               errs;
      errs = 0;
      if (reset) begin
         for (int r = 0; r < RESOURCES; r++) slot_map[r] = '0;
         awaited_results.delete();
         mismatches   <= 0;
         results_seen <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.status         = rsp_tdata[0 +: STATUS_W];
            seen.resource_index = rsp_tdata[STATUS_W +: RES_INDEX_W];
            seen.busy_count     = rsp_tdata[STATUS_W + RES_INDEX_W +: BUSY_W];
            results_seen <= results_seen + 1;
            if (awaited_results.size() == 0) begin
               $error("result item arrived with no request outstanding");
               errs++;
            end else begin
               want = awaited_results.pop_front();
               if (seen.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, seen.status);
                  errs++;
               end
               if (seen.resource_index !== want.resource_index) begin
                  $error("resource_index: expected %0d, got %0d",
                         want.resource_index, seen.resource_index);
                  errs++;
               end
               if (seen.busy_count !== want.busy_count) begin
                  $error("busy_count: expected %0d, got %0d",
                         want.busy_count, seen.busy_count);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            awaited_results.insert(awaited_results.size(),
                                   allocate_or_count(req_tuser[0 +: ACTION_W],
                                                     32'(req_tdata[0 +: DAY_W]),
                                                     32'(req_tdata[DAY_W +: DURATION_W])));
         end
         mismatches <= mismatches + errs;
      end
      pending <= awaited_results.size();
   end

endmodule

FILE: test/first_fit_interval_allocator_top_tb.sv
// Testbench top for the first-fit interval allocator: stimulus, hold-offs and verdict.
module first_fit_interval_allocator_top_tb;
   import ffia_pkg::*;

   // The tail after the last result allows more than twice the time of the
   // slowest item, a count or a failed assign.
   localparam int RESOURCES      = 16;
   localparam int DRAIN_CYCLES   = 2 * RESOURCES + 8;
   // The longest quiet spell in a correct run is the receiver's deliberate
   // hold-off of HOLD_CYCLES; the watchdog sits well above it.
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 450;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Fields from bit 0: day [6:0], duration [11:7], zero fill [15:12].
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   // Fields from bit 0: action [0].
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Fields from bit 0: status [1:0], resource_index [5:2], busy_count [10:6],
   // zero fill [15:11].
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int  mismatches;
   int  pending;
   int  results_seen;
   int  items_sent    = 0;
   int  quiet_cycles  = 0;
   bit  sender_calm   = 1'b0;
   bit  hold_done     = 1'b0;

   // The clock runs with a period of eight time units.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   first_fit_interval_allocator_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   first_fit_interval_allocator_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .mismatches   (mismatches),
      .pending      (pending),
      .results_seen (results_seen)
   );

   // Idle spells for either side: half of them none at all, most of the rest
   // brief, and now and then a long one.
   function automatic int idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      else if (roll < 90) return $urandom_range(1, 3);
      else return $urandom_range(10, 40);
   endfunction

   // Offers one item and returns once it has been taken. When no idle spell is
   // drawn, tvalid simply stays high from the previous item, so it never sees
   // two assignments in the same time step.
   task automatic offer_item(input logic [ACTION_W-1:0] action,
                             input logic [DAY_W-1:0] day,
                             input logic [DURATION_W-1:0] dur);
      int idle;
      idle = sender_calm ? 0 : idle_length();
      if (idle > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= {{(REQ_TDATA_W - DURATION_W - DAY_W){1'b0}}, dur, day};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // Receiver. Mostly it draws short stalls, but it has calm stretches where it
   // is always ready, and once, some way into the random part, it holds off for
   // a long while so that the result register fills and the input stalls.
   initial begin
      int stall;
      int turn;
      turn = 0;
      do @(posedge clock); while (reset);
      forever begin
         if (!hold_done && results_seen >= 40) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            stall = ((turn % 300) < 60) ? 0 : idle_length();
            turn++;
            if (stall == 0) begin
               rsp_tready <= 1'b1;
               @(posedge clock);
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
      end
   end

   // Watchdog: any cycle in which neither channel moves an item counts towards
   // the limit; one that does resets the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      int          roll;
      int          directed_items;
      logic [DAY_W-1:0]      day;
      logic [DURATION_W-1:0] dur;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Slot 0 is claimed by the first two resources, then by
      // all the others, so that the next request for it finds none free.
      offer_item(ACT_ASSIGN, 7'd0,   5'd1);
      offer_item(ACT_ASSIGN, 7'd0,   5'd16);
      // A window that ends exactly on the last slot fits; one slot later does not.
      offer_item(ACT_ASSIGN, 7'd112, 5'd16);
      offer_item(ACT_ASSIGN, 7'd113, 5'd16);
      // Zero and overlong durations are rejected, the widest one at the last slot too.
      offer_item(ACT_ASSIGN, 7'd10,  5'd0);
      offer_item(ACT_ASSIGN, 7'd10,  5'd17);
      offer_item(ACT_ASSIGN, 7'd127, 5'd31);
      // The last slot alone is free only from the second resource onwards.
      offer_item(ACT_ASSIGN, 7'd127, 5'd1);
      // Counts ignore the duration field, so give them odd values there.
      offer_item(ACT_COUNT,  7'd127, 5'd31);
      offer_item(ACT_COUNT,  7'd5,   5'd0);
      repeat (RESOURCES - 2) offer_item(ACT_ASSIGN, 7'd0, 5'd1);
      offer_item(ACT_ASSIGN, 7'd0, 5'd1);
      offer_item(ACT_COUNT,  7'd0, 5'd16);
      directed_items = items_sent;

      // Random part. Most items are assigns that fit the table, half of them
      // crowded into the low slots so that resources run out there early; the
      // rest are counts and assigns with any day and duration at all.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 75 == 0) sender_calm = ($urandom_range(0, 2) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 15) begin
            offer_item(ACT_COUNT, DAY_W'($urandom()), DURATION_W'($urandom()));
         end else if (roll < 25) begin
            offer_item(ACT_ASSIGN, DAY_W'($urandom()), DURATION_W'($urandom()));
         end else begin
            dur = DURATION_W'($urandom_range(1, 16));
            if (roll < 60) day = DAY_W'($urandom_range(0, 24));
            else day = DAY_W'($urandom_range(0, 128 - dur));
            offer_item(ACT_ASSIGN, day, dur);
         end
      end
      req_tvalid <= 1'b0;

      // The checker's count of outstanding results is registered, so it lags the
      // handshake; after it reaches zero a short tail catches any stray result.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d request items (%0d directed) and %0d result items,",
               items_sent, directed_items, results_seen);
      $display("with exhausted slots, range errors and a long receiver hold-off.");
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
